[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each macro places one labeled concurrent assertion on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed: %m");
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen: %m");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[rtl/ncm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ncm_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned ENERGY_W = 39;
  localparam int unsigned MUTE_W   = 4;
  // samples summed per cycle by the accumulator
  localparam int unsigned GROUP    = 8;
  // squared sample: |s| <= 32768, so s*s < 2^31
  localparam int unsigned SQ_W     = 31;
  // energy update terms: e << 16 plus sq*655 << 8 stays below 2^56
  localparam int unsigned PROD_W   = 57;

  localparam int MIX_LIMIT = 32000;
  // 0.01 in Q16
  localparam int COEF_NEW  = 655;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ENERGY_W-1:0]        energy_t;

  localparam sample_t MIX_POS  = sample_t'(MIX_LIMIT);
  localparam sample_t MIX_NEG  = sample_t'(-MIX_LIMIT);
  localparam sample_t UNIT_POS = sample_t'(1);
  localparam sample_t UNIT_NEG = sample_t'(-1);

  // lane controls from the sequencer
  typedef struct packed {
    logic sq_en;   // register the square of the lane's sample
    logic upd_en;  // commit the energy update
  } lane_ctrl_t;

endpackage

`default_nettype wire

[rtl/ncm_intf.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input items: one sample time across all channels
interface ncm_in_if import ncm_pkg::*; #(
  parameter int unsigned NumCh = 4
) ();
  logic                    valid;
  logic                    ready;
  sample_t [NumCh-1:0]     sample;
  logic    [NumCh-1:0]     contrib;

  modport source (output valid, sample, contrib, input ready);
  modport sink   (input valid, sample, contrib, output ready);
endinterface

// Result items: per-channel mix and energy
interface ncm_out_if import ncm_pkg::*; #(
  parameter int unsigned NumCh = 4
) ();
  logic                    valid;
  logic                    ready;
  sample_t [NumCh-1:0]     mix;
  energy_t [NumCh-1:0]     energy;

  modport source (output valid, mix, energy, input ready);
  modport sink   (input valid, mix, energy, output ready);
endinterface

// Mute mask writes
interface ncm_cfg_if import ncm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MUTE_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[rtl/n_minus_one_conference_mixer.sv]
// N-minus-one conference mixer.
// in_i: one item per sample time, a signed 16-bit sample and a contrib flag
//   for every channel. out_o: one result item per input item, each
//   channel's mix of the other contributors clipped to +/-32000 (-1/0/+1 for
//   channels set in the mute mask), plus each channel's energy average.
// cfg_i: writes the 4-bit mute mask; always ready, write only while idle.
// Timing: an item is taken in the idle state, the accumulator then sums
//   8 channels per cycle over ceil(NUM_CHANNELS/8) steps, and the finishing
//   state lets all lanes load the output register, whose result is then
//   valid. No new item is taken until the finishing state has loaded the
//   output register.
// Stall: the output register holds its result while out ready is low; the
//   next item is accepted and summed meanwhile and waits in the finishing
//   cycle until the register is taken.
// Reset: energies and mute mask clear to zero, no result is pending, the
//   block is ready for an item as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module n_minus_one_conference_mixer import ncm_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ncm_in_if.sink     in_i,
  ncm_out_if.source  out_o,
  ncm_cfg_if.sink    cfg_i
);

  localparam int unsigned Steps = (NUM_CHANNELS + GROUP - 1) / GROUP;
  localparam int unsigned SumW  = SAMPLE_W + $clog2(NUM_CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  sample_t [NUM_CHANNELS-1:0]      smp_q;
  logic    [NUM_CHANNELS-1:0]      con_q;
  logic    [MUTE_W-1:0]            mute_q;
  logic    [NUM_CHANNELS-1:0]      mute_lane;
  logic                            out_valid_q;
  sample_t [NUM_CHANNELS-1:0]      mix_q;
  energy_t [NUM_CHANNELS-1:0]      energy_q;
  sample_t [NUM_CHANNELS-1:0]      lane_mix;
  energy_t [NUM_CHANNELS-1:0]      lane_energy;
  sample_t [Steps-1:0][GROUP-1:0]  pad_smp;
  logic    [Steps-1:0][GROUP-1:0]  pad_con;
  sample_t [GROUP-1:0]             grp_smp;
  logic    [GROUP-1:0]             grp_con;
  logic signed [SumW-1:0]          sum;
  logic                            in_fire;
  logic                            last_step;
  logic                            out_free;
  logic                            fin_load;
  lane_ctrl_t                      lane_ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign fin_load   = (state_q == ST_FIN) && out_free;

  // capture the item
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= in_i.sample;
      con_q <= in_i.contrib;
    end
  end

  // mute mask register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      mute_q <= cfg_i.data;
    end
  end

  // channels padded to whole groups; padding never contributes
  for (genvar k = 0; k < Steps * GROUP; k++) begin : g_pad
    if (k < NUM_CHANNELS) begin : g_real
      assign pad_smp[k / GROUP][k % GROUP] = smp_q[k];
      assign pad_con[k / GROUP][k % GROUP] = con_q[k];
    end else begin : g_fill
      assign pad_smp[k / GROUP][k % GROUP] = '0;
      assign pad_con[k / GROUP][k % GROUP] = 1'b0;
    end
  end

  // group counter
  if (Steps > 1) begin : g_multi
    localparam int unsigned IdxW = $clog2(Steps);
    logic [IdxW-1:0] idx_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        idx_q <= '0;
      end else if (in_fire) begin
        idx_q <= '0;
      end else if (state_q == ST_SUM) begin
        idx_q <= idx_q + 1'b1;
      end
    end

    assign grp_smp   = pad_smp[idx_q];
    assign grp_con   = pad_con[idx_q];
    assign last_step = (idx_q == IdxW'(Steps - 1));
  end else begin : g_single
    assign grp_smp   = pad_smp[0];
    assign grp_con   = pad_con[0];
    assign last_step = 1'b1;
  end

  ncm_acc #(
    .SumW (SumW)
  ) u_acc (
    .clk_i (clk_i),
    .clr_i (in_fire),
    .en_i  (state_q == ST_SUM),
    .smp_i (grp_smp),
    .con_i (grp_con),
    .sum_o (sum)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (last_step) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign lane_ctrl.sq_en  = (state_q == ST_SUM);
  assign lane_ctrl.upd_en = fin_load;

  // lanes; only the first channels have a mute bit
  for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_lane
    if (k < MUTE_W) begin : g_mute
      assign mute_lane[k] = mute_q[k];
    end else begin : g_nomute
      assign mute_lane[k] = 1'b0;
    end

    ncm_lane #(
      .SumW (SumW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .sample_i  (smp_q[k]),
      .contrib_i (con_q[k]),
      .sum_i     (sum),
      .mute_i    (mute_lane[k]),
      .ctrl_i    (lane_ctrl),
      .mix_o     (lane_mix[k]),
      .energy_o  (lane_energy[k])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      mix_q    <= lane_mix;
      energy_q <= lane_energy;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.mix    = mix_q;
  assign out_o.energy = energy_q;

  `ASSERT_AT(a_state_onehot, clk_i, rst_ni, $onehot(state_q))
  `ASSERT_AT(a_accept_to_sum, clk_i, rst_ni, in_fire |=> (state_q == ST_SUM))
  `ASSERT_AT(a_result_held, clk_i, rst_ni, (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(mix_q) && $stable(energy_q)))

endmodule

`default_nettype wire

[rtl/ncm_acc.sv]
`timescale 1ns / 1ps
`default_nettype none

// Accumulates the contributing samples of one group per cycle while enabled.
module ncm_acc import ncm_pkg::*; #(
  parameter int unsigned SumW = 18
) (
  input  logic                   clk_i,
  input  logic                   clr_i,
  input  logic                   en_i,
  input  sample_t [GROUP-1:0]    smp_i,
  input  logic    [GROUP-1:0]    con_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [SumW-1:0] acc_q;
  logic signed [SumW-1:0] acc_d;

  // add the group's contributors to the running sum
  always_comb begin
    acc_d = acc_q;
    for (int j = 0; j < GROUP; j++) begin
      if (con_i[j]) begin
        acc_d = acc_d + SumW'($signed(smp_i[j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule

`default_nettype wire

[rtl/ncm_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One channel: own-sample removal, clip, mute and energy average.
module ncm_lane import ncm_pkg::*; #(
  parameter int unsigned SumW = 18
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sample_t                sample_i,
  input  logic                   contrib_i,
  input  logic signed [SumW-1:0] sum_i,
  input  logic                   mute_i,
  input  lane_ctrl_t             ctrl_i,
  output sample_t                mix_o,
  output energy_t                energy_o
);

  localparam int unsigned VW = SumW + 1;

  logic signed [31:0]   sq_full;
  logic [SQ_W-1:0]      sq_q;
  energy_t              energy_q;
  logic signed [VW-1:0] own;
  logic signed [VW-1:0] v;
  sample_t              clip;
  logic [PROD_W-1:0]    upd_sum;
  energy_t              e_new;

  // squared sample, registered ahead of the energy update
  assign sq_full = 32'(sample_i) * 32'(sample_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq_en) begin
      sq_q <= sq_full[SQ_W-1:0];
    end
  end

  // mix less own sample, clipped to the limit
  assign own = contrib_i ? VW'(sample_i) : '0;
  assign v   = VW'(sum_i) - own;

  always_comb begin
    if (v > VW'(MIX_LIMIT)) begin
      clip = MIX_POS;
    end else if (v < -VW'(MIX_LIMIT)) begin
      clip = MIX_NEG;
    end else begin
      clip = v[SAMPLE_W-1:0];
    end
  end

  // muted: +1 at the positive limit, -1 at the negative limit, else 0
  always_comb begin
    if (!mute_i) begin
      mix_o = clip;
    end else if (clip == MIX_POS) begin
      mix_o = UNIT_POS;
    end else if (clip == MIX_NEG) begin
      mix_o = UNIT_NEG;
    end else begin
      mix_o = '0;
    end
  end

  // e' = (sq*256*655 + e*(65536-655)) >> 16
  assign upd_sum = ((PROD_W'(sq_q) * PROD_W'(COEF_NEW)) << 8)
                 + (PROD_W'(energy_q) << 16)
                 - (PROD_W'(energy_q) * PROD_W'(COEF_NEW));
  assign e_new   = upd_sum[ENERGY_W+15:16];

  assign energy_o = contrib_i ? e_new : energy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
    end else if (ctrl_i.upd_en && contrib_i) begin
      energy_q <= e_new;
    end
  end

  `ASSERT_AT(a_mix_range, clk_i, rst_ni, ctrl_i.upd_en |-> ((mix_o <= MIX_POS) && (mix_o >= MIX_NEG)))
  `ASSERT_AT(a_energy_hold, clk_i, rst_ni, !(ctrl_i.upd_en && contrib_i) |=> $stable(energy_q))

endmodule

`default_nettype wire
